### design/almd_pkg.sv
// almd_pkg: shared types and constants for the ambient light LED dimmer.
// Used by almd_cfg_regs, almd_step and ambient_light_led_dimmer_core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package almd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int LUX_W      = 16;
  localparam int TIME_W     = 32;
  localparam int STEP_W     = 6;
  localparam int LEVEL_W    = 11;
  localparam int GOOD_W     = 10;
  localparam int CNT_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LUX     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_INTERVAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE      = 2'd3;

  localparam logic [LUX_W-1:0]  TARGET_LUX_RST     = 16'd0;
  localparam logic [LUX_W-1:0]  TOLERANCE_RST      = 16'd10;
  localparam logic [TIME_W-1:0] PROBE_INTERVAL_RST = 32'd1000;
  localparam logic [STEP_W-1:0] STEP_SIZE_RST      = 6'd5;

  localparam logic signed [LEVEL_W-1:0] LEVEL_RST  = 11'sd100;
  localparam logic signed [LEVEL_W:0]   LEVEL_MAX  = 12'sd1023;
  localparam logic [CNT_W-1:0]          SAME_LIMIT = 3'd4;

  typedef struct packed {
    logic [LUX_W-1:0]  target_lux;
    logic [LUX_W-1:0]  tolerance;
    logic [TIME_W-1:0] probe_interval;
    logic [STEP_W-1:0] step_size;
  } cfg_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic                      probing;
    logic [TIME_W-1:0]         probe_time;
    logic [LUX_W-1:0]          probe_lux;
    logic [GOOD_W-1:0]         good_level;
    logic [CNT_W-1:0]          same_count;
  } state_t;

endpackage
`default_nettype wire

### design/ambient_light_led_dimmer_core.sv
// ambient_light_led_dimmer_core: top level of the ambient light LED dimmer.
// Depends on almd_pkg, almd_cfg_regs and almd_step.
//
//   port group | dir | beat contents
//   in_*       | in  | lux reading, millisecond time stamp
//   out_*      | out | LED drive percent (signed)
//   cfg_*      | in  | register index, write data
//
// One beat per cycle while the output is not stalled; a result appears in the cycle after its input beat.
// Throughput is set by the single output register: a new beat is taken
// whenever that register is empty or being drained in the same cycle.
// Synchronous active-low reset loads the register and state defaults.
// A stalled output holds its beat and blocks further input beats.
`timescale 1ns / 1ps
`default_nettype none
module ambient_light_led_dimmer_core (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire [almd_pkg::LUX_W-1:0]              in_lux,
  input  wire [almd_pkg::TIME_W-1:0]             in_time_now,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic signed [almd_pkg::LEVEL_W-1:0]    out_drive_percent,
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire [almd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire [almd_pkg::CFG_DATA_W-1:0]         cfg_data
);

  almd_pkg::cfg_t   cfg;
  almd_pkg::state_t state_r;
  almd_pkg::state_t state_nxt;

  logic                                 out_valid_r;
  logic signed [almd_pkg::LEVEL_W-1:0]  drive_r;
  logic                                 in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  almd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  almd_step u_step (
    .cfg      (cfg),
    .cur      (state_r),
    .lux      (in_lux),
    .time_now (in_time_now),
    .nxt      (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.level      <= almd_pkg::LEVEL_RST;
      state_r.probing    <= 1'b0;
      state_r.probe_time <= '0;
      state_r.probe_lux  <= '0;
      state_r.good_level <= '0;
      state_r.same_count <= '0;
      out_valid_r        <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      drive_r <= state_nxt.level;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_percent = drive_r;

endmodule
`default_nettype wire

### design/almd_cfg_regs.sv
// almd_cfg_regs: configuration register file of the dimmer.
// Depends on almd_pkg (cfg_t, register indexes, reset values).
`timescale 1ns / 1ps
`default_nettype none
module almd_cfg_regs (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                wr_en,
  input  wire [almd_pkg::CFG_IDX_W-1:0]      wr_index,
  input  wire [almd_pkg::CFG_DATA_W-1:0]     wr_data,
  output almd_pkg::cfg_t                     cfg
);

  almd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_lux     <= almd_pkg::TARGET_LUX_RST;
      cfg_r.tolerance      <= almd_pkg::TOLERANCE_RST;
      cfg_r.probe_interval <= almd_pkg::PROBE_INTERVAL_RST;
      cfg_r.step_size      <= almd_pkg::STEP_SIZE_RST;
    end else if (wr_en) begin
      case (wr_index)
        almd_pkg::REG_TARGET_LUX:     cfg_r.target_lux     <= wr_data[almd_pkg::LUX_W-1:0];
        almd_pkg::REG_TOLERANCE:      cfg_r.tolerance      <= wr_data[almd_pkg::LUX_W-1:0];
        almd_pkg::REG_PROBE_INTERVAL: cfg_r.probe_interval <= wr_data[almd_pkg::TIME_W-1:0];
        almd_pkg::REG_STEP_SIZE:      cfg_r.step_size      <= wr_data[almd_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### design/almd_step.sv
// almd_step: next-state logic for one light reading (clamp, probe, step).
// Depends on almd_pkg (cfg_t, state_t, constants).
`timescale 1ns / 1ps
`default_nettype none
module almd_step (
  input  wire almd_pkg::cfg_t             cfg,
  input  wire almd_pkg::state_t           cur,
  input  wire [almd_pkg::LUX_W-1:0]       lux,
  input  wire [almd_pkg::TIME_W-1:0]      time_now,
  output almd_pkg::state_t                nxt
);

  logic signed [almd_pkg::LEVEL_W-1:0] lvl0;
  logic signed [almd_pkg::LEVEL_W:0]   lvl12;
  logic signed [almd_pkg::LEVEL_W:0]   stp12;
  logic signed [almd_pkg::LEVEL_W:0]   up12;
  logic [almd_pkg::TIME_W-1:0]         elapsed;
  logic [almd_pkg::LUX_W-1:0]          tgt_diff;
  logic [almd_pkg::LUX_W-1:0]          probe_diff;
  logic [almd_pkg::CNT_W-1:0]          cnt_inc;
  logic                                near;
  logic                                lux_gt;
  logic                                lvl_zero;
  logic                                changed;
  logic                                go_normal;

  always_comb begin
    lvl0     = cur.level[almd_pkg::LEVEL_W-1] ? '0 : cur.level;
    lvl_zero = (lvl0 == '0);
    lvl12    = {lvl0[almd_pkg::LEVEL_W-1], lvl0};
    stp12    = $signed({{(almd_pkg::LEVEL_W+1-almd_pkg::STEP_W){1'b0}}, cfg.step_size});
    up12     = lvl12 + stp12;

    elapsed    = (cur.probe_time > time_now) ? (cur.probe_time - time_now)
                                             : (time_now - cur.probe_time);
    tgt_diff   = (lux >= cfg.target_lux) ? (lux - cfg.target_lux) : (cfg.target_lux - lux);
    probe_diff = (cur.probe_lux >= lux) ? (cur.probe_lux - lux) : (lux - cur.probe_lux);
    near       = tgt_diff < cfg.tolerance;
    lux_gt     = lux > cfg.target_lux;
    changed    = probe_diff > cfg.tolerance;
    cnt_inc    = cur.same_count + 1'b1;

    nxt       = cur;
    nxt.level = lvl0;
    go_normal = 1'b0;

    if ((elapsed > cfg.probe_interval) && (near || lux_gt) && !cur.probing) begin
      nxt.probing    = 1'b1;
      nxt.probe_time = time_now;
      nxt.probe_lux  = lux;
      nxt.level      = almd_pkg::LEVEL_W'(lvl12 - stp12);
    end else if (cur.probing) begin
      if (changed) begin
        nxt.same_count = '0;
        nxt.probing    = 1'b0;
        go_normal      = 1'b1;
      end else if (cnt_inc == almd_pkg::SAME_LIMIT) begin
        nxt.same_count = '0;
        nxt.probing    = 1'b0;
        nxt.level      = '0;
      end else begin
        nxt.same_count = cnt_inc;
        nxt.level      = almd_pkg::LEVEL_W'(lvl12 - (stp12 <<< 1));
      end
    end else begin
      go_normal = 1'b1;
    end

    if (go_normal) begin
      if (near) begin
        nxt.good_level = lvl0[almd_pkg::GOOD_W-1:0];
      end else if (!(lux < cfg.target_lux) && lvl_zero) begin
        nxt.level = lvl0;
      end else if (lvl_zero && (cur.good_level != '0)) begin
        nxt.level = $signed({1'b0, cur.good_level});
      end else if (lux_gt) begin
        nxt.level = almd_pkg::LEVEL_W'(lvl12 - stp12);
      end else if (up12 > almd_pkg::LEVEL_MAX) begin
        nxt.level = almd_pkg::LEVEL_W'(almd_pkg::LEVEL_MAX);
      end else begin
        nxt.level = almd_pkg::LEVEL_W'(up12);
      end
    end
  end

endmodule
`default_nettype wire
